[rtl/ppp_pkg.sv]
// package for the perspective projection unit
// shared types for the divider cell chain; no dependencies
package ppp_pkg;

    localparam int NUM_CELLS = 32;
    localparam int NUM_LANES = 3;

    typedef enum logic [1:0] {
        REG_X_SCALE      = 2'd0,
        REG_Y_SCALE      = 2'd1,
        REG_DEPTH_SCALE  = 2'd2,
        REG_DEPTH_OFFSET = 2'd3
    } t_reg_idx;

    // one quotient lane of the restoring divider
    typedef struct packed {
        logic        neg;   // result sign
        logic        ovf;   // quotient >= 2^32
        logic [31:0] rem;   // partial remainder
        logic [31:0] num;   // numerator bits still to shift in
        logic [31:0] quo;   // quotient bits so far
    } t_lane;

    typedef struct packed {
        logic                       valid;
        logic                       dbz;
        logic [31:0]                dmag;
        t_lane [NUM_LANES-1:0]      lane;
    } t_div;

endpackage

[rtl/ppp_front.sv]
// front end: sparse matrix multiply and divider set-up, two register stages
// depends on ppp_pkg
module ppp_front import ppp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic [31:0] i_point_w,
    input  logic [31:0] i_x_scale,
    input  logic [31:0] i_y_scale,
    input  logic [31:0] i_depth_scale,
    input  logic [31:0] i_depth_offset,
    output t_div        o_div
);
    logic               r_valid1;
    logic signed [63:0] r_cx, r_cy, r_pa, r_pb;
    logic [31:0]        r_pz;
    t_div               r_div, n_div;
    logic signed [64:0] s_z;
    logic [63:0]        nmag [NUM_LANES];
    logic [NUM_LANES-1:0] nneg;
    logic               dneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx <= $signed(i_point_x) * $signed(i_x_scale);
            r_cy <= $signed(i_point_y) * $signed(i_y_scale);
            r_pa <= $signed(i_point_z) * $signed(i_depth_scale);
            r_pb <= $signed(i_point_w) * $signed(i_depth_offset);
            r_pz <= i_point_z;
        end
    end

    always_comb begin
        s_z     = 65'(r_pa) + 65'(r_pb);
        nneg[0] = r_cx[63];
        nneg[1] = r_cy[63];
        nneg[2] = s_z[64];
        nmag[0] = r_cx[63] ? 64'(-r_cx) : 64'(r_cx);
        nmag[1] = r_cy[63] ? 64'(-r_cy) : 64'(r_cy);
        nmag[2] = s_z[64] ? 64'(-s_z) : 64'(s_z);
        // clip w = -z, so it is negative when z is positive
        dneg    = !r_pz[31] && (r_pz != 32'd0);
        n_div.valid = r_valid1;
        n_div.dbz   = (r_pz == 32'd0);
        n_div.dmag  = r_pz[31] ? 32'(-r_pz) : r_pz;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_div.lane[l].neg = nneg[l] ^ dneg;
            n_div.lane[l].ovf = (nmag[l][63:32] >= n_div.dmag);
            n_div.lane[l].rem = nmag[l][63:32];
            n_div.lane[l].num = nmag[l][31:0];
            n_div.lane[l].quo = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.valid <= 1'b0;
        end else if (i_en) begin
            r_div.valid <= n_div.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div.dbz  <= n_div.dbz;
            r_div.dmag <= n_div.dmag;
            r_div.lane <= n_div.lane;
        end
    end

    assign o_div = r_div;
endmodule

[rtl/ppp_div_cell.sv]
// one restoring divider cell: one quotient bit for each of the three lanes
// depends on ppp_pkg
module ppp_div_cell import ppp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_div,
    output t_div o_div
);
    t_div        r_div, n_div;
    logic [32:0] trial [NUM_LANES];
    logic [NUM_LANES-1:0] ge;

    always_comb begin
        n_div = i_div;
        for (int l = 0; l < NUM_LANES; l++) begin
            trial[l] = {i_div.lane[l].rem, i_div.lane[l].num[31]};
            ge[l]    = (trial[l] >= {1'b0, i_div.dmag});
            n_div.lane[l].rem = ge[l] ? 32'(trial[l] - {1'b0, i_div.dmag})
                                      : trial[l][31:0];
            n_div.lane[l].num = {i_div.lane[l].num[30:0], 1'b0};
            n_div.lane[l].quo = {i_div.lane[l].quo[30:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.valid <= 1'b0;
        end else if (i_en) begin
            r_div.valid <= n_div.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div.dbz  <= n_div.dbz;
            r_div.dmag <= n_div.dmag;
            r_div.lane <= n_div.lane;
        end
    end

    assign o_div = r_div;
endmodule

[rtl/ppp_back.sv]
// back end: sign, saturation and zero-divisor handling into the output register
// depends on ppp_pkg
module ppp_back import ppp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_div        i_div,
    output logic        o_valid,
    output logic [31:0] o_ndc_x,
    output logic [31:0] o_ndc_y,
    output logic [31:0] o_ndc_z,
    output logic        o_divide_by_zero,
    output logic        o_saturated
);
    logic        r_valid;
    logic [31:0] r_val [NUM_LANES];
    logic [31:0] n_val [NUM_LANES];
    logic        r_dbz, r_sat, n_sat;
    logic [NUM_LANES-1:0] lsat;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (i_div.lane[l].neg) begin
                lsat[l]  = i_div.lane[l].ovf || (i_div.lane[l].quo > 32'h8000_0000);
                n_val[l] = lsat[l] ? 32'h8000_0000 : 32'(-i_div.lane[l].quo);
            end else begin
                lsat[l]  = i_div.lane[l].ovf || i_div.lane[l].quo[31];
                n_val[l] = lsat[l] ? 32'h7FFF_FFFF : i_div.lane[l].quo;
            end
            if (i_div.dbz) begin
                n_val[l] = 32'd0;
            end
        end
        n_sat = (|lsat) && !i_div.dbz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_div.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
            r_dbz <= i_div.dbz;
            r_sat <= n_sat;
        end
    end

    assign o_valid          = r_valid;
    assign o_ndc_x          = r_val[0];
    assign o_ndc_y          = r_val[1];
    assign o_ndc_z          = r_val[2];
    assign o_divide_by_zero = r_dbz;
    assign o_saturated      = r_sat;
endmodule

[rtl/perspective_project_point.sv]
// top level of the perspective projection unit with divide
// depends on ppp_pkg, ppp_front, ppp_div_cell and ppp_back
//
// projects one homogeneous Q16.16 point per cycle unless held: clip x =
// x*x_scale, clip y = y*y_scale, clip z = z*depth_scale + w*depth_offset,
// clip w = -z, then divides the first three by clip w, truncating toward
// zero and clamping to 32 bits (saturated flag). when z is zero the outputs
// are zero and divide_by_zero is set. a request enters each cycle unless
// held. stages: one multiply stage, one set-up stage, a chain of 32 divider
// cells that each settle one quotient bit of all three lanes against the
// shared divisor, and the output register. the whole pipe advances together
// and holds only while a finished result is stalled at the output.
// configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_data
// and must only change while the pipe is empty.
module perspective_project_point import ppp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic [31:0] i_point_w,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_ndc_x,
    output logic [31:0] o_ndc_y,
    output logic [31:0] o_ndc_z,
    output logic        o_divide_by_zero,
    output logic        o_saturated,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_x_scale, r_y_scale, r_depth_scale, r_depth_offset;
    logic        en;
    t_div        chain [NUM_CELLS+1];

    // matrix registers, reset to the identity-like default
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale      <= 32'h0001_0000;
            r_y_scale      <= 32'h0001_0000;
            r_depth_scale  <= 32'hFFFF_0000;
            r_depth_offset <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_X_SCALE:      r_x_scale      <= i_cfg_data;
                REG_Y_SCALE:      r_y_scale      <= i_cfg_data;
                REG_DEPTH_SCALE:  r_depth_scale  <= i_cfg_data;
                REG_DEPTH_OFFSET: r_depth_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipe moves unless the output holds a result that is stalled
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    ppp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_valid),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_point_w      (i_point_w),
        .i_x_scale      (r_x_scale),
        .i_y_scale      (r_y_scale),
        .i_depth_scale  (r_depth_scale),
        .i_depth_offset (r_depth_offset),
        .o_div          (chain[0])
    );

    // divider chain, msb of the quotient first
    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        ppp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_div   (chain[c]),
            .o_div   (chain[c+1])
        );
    end

    ppp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_div            (chain[NUM_CELLS]),
        .o_valid          (o_valid),
        .o_ndc_x          (o_ndc_x),
        .o_ndc_y          (o_ndc_y),
        .o_ndc_z          (o_ndc_z),
        .o_divide_by_zero (o_divide_by_zero),
        .o_saturated      (o_saturated)
    );

    // zero divisor gives zero outputs
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_ndc_x == 32'd0 && o_ndc_y == 32'd0
                                        && o_ndc_z == 32'd0 && !o_saturated)
        else $error("divide by zero result not cleared");

    // a stalled result holds the whole pipe
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while output stalled");

    // a held result stays valid and keeps its x and z outputs
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ndc_x) && $stable(o_ndc_z))
        else $error("stalled result changed");

    // reset empties the pipe
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

[dv/tb.sv]
// testbench for perspective_project_point: projection with divide, checked per request
// depends on ppp_pkg and the rtl of perspective_project_point

// predicted projections, kept in request order and compared with each result
class proj_scoreboard;
    logic [31:0] q_x[$], q_y[$], q_z[$];
    logic        q_dbz[$], q_sat[$];
    int          mismatches;
    logic signed [31:0] xs, ys, zs, zo;

    function new();
        mismatches = 0;
        xs = 32'sh0001_0000; ys = 32'sh0001_0000; zs = -32'sh0001_0000; zo = 0;
    endfunction

    function int pending();
        return q_x.size();
    endfunction

    // truncating divide of a signed 66-bit numerator, clamped to 32 bits
    function logic [31:0] div_clamp(logic signed [65:0] num, logic signed [33:0] den,
                                    ref logic sat);
        logic signed [65:0] q;
        q = num / den;
        if (q > 66'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (q < -66'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return q[31:0];
    endfunction

    function void note_point(logic signed [31:0] px, py, pz, pw);
        logic signed [33:0] cw;
        logic signed [65:0] cx, cy, cz;
        logic sat;
        cw = -$signed({{2{pz[31]}}, pz});
        sat = 1'b0;
        if (cw == 0) begin
            q_x.push_back(0); q_y.push_back(0); q_z.push_back(0);
            q_dbz.push_back(1'b1); q_sat.push_back(1'b0);
            return;
        end
        cx = 66'(px) * 66'(xs);
        cy = 66'(py) * 66'(ys);
        cz = 66'(pz) * 66'(zs) + 66'(pw) * 66'(zo);
        q_x.push_back(div_clamp(cx, cw, sat));
        q_y.push_back(div_clamp(cy, cw, sat));
        q_z.push_back(div_clamp(cz, cw, sat));
        q_dbz.push_back(1'b0);
        q_sat.push_back(sat);
    endfunction

    function void check_result(logic [31:0] nx, ny, nz, logic dbz, sat);
        logic [31:0] ex, ey, ez;
        logic edbz, esat;
        if (q_x.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h %h %h", nx, ny, nz);
            return;
        end
        ex = q_x.pop_front(); ey = q_y.pop_front(); ez = q_z.pop_front();
        edbz = q_dbz.pop_front(); esat = q_sat.pop_front();
        if (nx !== ex || ny !== ey || nz !== ez || dbz !== edbz || sat !== esat) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp %h %h %h dbz %b sat %b got %h %h %h dbz %b sat %b",
                         ex, ey, ez, edbz, esat, nx, ny, nz, dbz, sat);
        end
    endfunction
endclass

module tb import ppp_pkg::*;;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall, o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] i_point_x, i_point_y, i_point_z, i_point_w;
    logic [31:0] o_ndc_x, o_ndc_y, o_ndc_z;
    logic        o_divide_by_zero, o_saturated;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // idle percentages for sender and receiver, changed per phase
    int send_idle_pct, recv_stall_pct;
    proj_scoreboard sb;

    perspective_project_point DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // generous cap on the whole run
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver: random stall, result checked on each accepted handshake
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_ndc_x, o_ndc_y, o_ndc_z, o_divide_by_zero, o_saturated);
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // register write while the pipe is empty
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_X_SCALE:      sb.xs = val;
            REG_Y_SCALE:      sb.ys = val;
            REG_DEPTH_SCALE:  sb.zs = val;
            REG_DEPTH_OFFSET: sb.zo = val;
        endcase
    endtask

    // one request, with optional random gaps before it; valid stays up afterwards
    task automatic send_point(logic [31:0] px, py, pz, pw);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_point_x <= px; i_point_y <= py; i_point_z <= pz; i_point_w <= pw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_point(px, py, pz, pw);
    endtask

    // wait until every result has come back, then let the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // random field: mostly small Q16.16 magnitudes, sometimes any 32-bit value
    function automatic logic [31:0] rnd_field();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(40)) - 20) <<< 16;
        endcase
    endfunction

    function automatic logic [31:0] rnd_z();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'h8000_0000;
            default: return rnd_field();
        endcase
    endfunction

    logic [31:0] edge_vals[6] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                                  32'hffff_0000, 32'hffff_ffff};

    initial begin
        sb = new();
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_point_x = 0; i_point_y = 0; i_point_z = 0; i_point_w = 0;
        i_cfg_we = 1'b0; i_cfg_index = REG_X_SCALE; i_cfg_data = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset coefficients, field extremes, zero and most negative z
        send_point(32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 32'h0001_0000);
        send_point(32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0001_0000);
        foreach (edge_vals[i])
            send_point(edge_vals[i], edge_vals[5-i], edge_vals[(i+2)%6], edge_vals[(i+4)%6]);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff);
        drain();

        // extreme coefficients
        write_reg(REG_X_SCALE, 32'h7fff_ffff);
        write_reg(REG_Y_SCALE, 32'h8000_0000);
        write_reg(REG_DEPTH_SCALE, 32'h8000_0000);
        write_reg(REG_DEPTH_OFFSET, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
        send_point(32'h0001_0000, 32'hffff_0000, 32'h0000_0001, 32'h8000_0000);
        send_point(32'h0, 32'h0, 32'h0, 32'h8000_0000);
        drain();

        // random phases: each picks an idling mode and new coefficients
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            write_reg(REG_X_SCALE, ph == 11 ? 32'h0 : rnd_field());
            write_reg(REG_Y_SCALE, rnd_field());
            write_reg(REG_DEPTH_SCALE, ph == 11 ? 32'hffff_0000 : rnd_field());
            write_reg(REG_DEPTH_OFFSET, rnd_field());
            for (int n = 0; n < 160; n++) begin
                send_point(rnd_field(), rnd_field(), rnd_z(), rnd_field());
                // sender holds off until the pipe has emptied
                if (ph == 5 && n == 80) begin
                    i_valid <= 1'b0;
                    while (sb.pending() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        recv_stall_pct = 0;
        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[filelist.f]
rtl/ppp_pkg.sv
rtl/ppp_front.sv
rtl/ppp_div_cell.sv
rtl/ppp_back.sv
rtl/perspective_project_point.sv
dv/tb.sv
